>>> hdl/cbd_pkg.sv
// Shared types, codes and constants for the chunked body decoder.
package cbd_pkg;

    localparam int SIZE_W          = 31;
    localparam int CNT_W           = 4;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0]       CHR_CR         = 8'h0D;
    localparam logic [7:0]       CHR_LF         = 8'h0A;
    localparam logic [CNT_W-1:0] MAX_DIGITS_RST = 4'd8;
    localparam logic [CNT_W-1:0] MAX_DIGITS_LO  = 4'd1;
    localparam logic [CNT_W-1:0] MAX_DIGITS_HI  = 4'd8;

    typedef logic [1:0] t_err;
    localparam t_err ERR_NONE = 2'd0;
    localparam t_err ERR_SIZE = 2'd1;
    localparam t_err ERR_TERM = 2'd2;

    typedef enum logic [5:0] {
        PH_SIZE    = 6'b000001,
        PH_SIZE_LF = 6'b000010,
        PH_DATA    = 6'b000100,
        PH_TERM_CR = 6'b001000,
        PH_TERM_LF = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       new_body;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       done_res;
        t_err       error_code;
    } t_out_item;

    // Classified byte as it travels from the front to the back
    typedef struct packed {
        logic [7:0] raw;
        logic       new_body;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } t_cls;

    // Clamp the digit limit register to its meaningful range
    function automatic logic [CNT_W-1:0] digit_limit(input logic [CNT_W-1:0] cfg);
        logic [CNT_W-1:0] lim;
        begin
            lim = cfg;
            if (cfg < MAX_DIGITS_LO) lim = MAX_DIGITS_LO;
            if (cfg > MAX_DIGITS_HI) lim = MAX_DIGITS_HI;
            return lim;
        end
    endfunction

endpackage

>>> hdl/cbd_front.sv
// Front end: takes input bytes and classifies them for the queue.
module cbd_front (
    input  logic            i_in_valid,
    input  cbd_pkg::t_in_item i_in_item,
    input  logic            i_q_full,
    output logic            o_in_stall,
    output logic            o_push,
    output cbd_pkg::t_cls   o_cls
);
    import cbd_pkg::*;

    function automatic t_cls classify(input logic [7:0] b, input logic nb);
        t_cls c;
        begin
            c          = '0;
            c.raw      = b;
            c.new_body = nb;
            c.is_cr    = (b == CHR_CR);
            c.is_lf    = (b == CHR_LF);
            case (b) inside
                [8'h30:8'h39]: begin
                    c.is_hex  = 1'b1;
                    c.hex_val = b[3:0];
                end
                [8'h41:8'h46], [8'h61:8'h66]: begin
                    c.is_hex  = 1'b1;
                    c.hex_val = b[3:0] + 4'd9;
                end
                default: begin
                    c.is_hex  = 1'b0;
                end
            endcase
            return c;
        end
    endfunction

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_cls      = classify(i_in_item.body_byte, i_in_item.new_body);

endmodule

>>> hdl/cbd_queue.sv
// Short queue of classified bytes between front and back.
module cbd_queue #(
    parameter int DEPTH = cbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cbd_pkg::t_cls i_data,
    input  logic          i_pop,
    output cbd_pkg::t_cls o_data,
    output logic          o_full,
    output logic          o_empty
);
    import cbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);

    t_cls              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            if (p == PTR_W'(DEPTH - 1)) return '0;
            return p + PTR_W'(1);
        end
    endfunction

    assign o_full  = (r_count == QCNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) n_count = r_count + QCNT_W'(1);
        if (!i_push && i_pop) n_count = r_count - QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> hdl/cbd_back.sv
// Back end: chunk framing state machine and output register.
module cbd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [cbd_pkg::CNT_W-1:0] i_max_digits,
    input  cbd_pkg::t_cls             i_cls,
    input  logic                      i_q_empty,
    output logic                      o_pop,
    output logic                      o_out_valid,
    output cbd_pkg::t_out_item        o_out_item,
    input  logic                      i_out_stall
);
    import cbd_pkg::*;

    t_phase            r_phase, n_phase, c_phase;
    logic [SIZE_W-1:0] r_acc, n_acc, c_acc;
    logic [CNT_W-1:0]  r_cnt, n_cnt, c_cnt;
    logic [SIZE_W-1:0] r_left, n_left, c_left;
    logic              r_last, n_last, c_last;
    t_err              r_err, n_err, c_err;
    logic              r_out_valid;
    t_out_item         r_out_item, n_out_item;
    logic              dvalid;
    logic [CNT_W-1:0]  lim;

    assign lim   = digit_limit(i_max_digits);
    // Advance when the output register is free or being emptied this cycle
    assign o_pop = !i_q_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        // new_body clears the body state before the byte is handled
        c_phase = i_cls.new_body ? PH_SIZE  : r_phase;
        c_acc   = i_cls.new_body ? '0       : r_acc;
        c_cnt   = i_cls.new_body ? '0       : r_cnt;
        c_left  = i_cls.new_body ? '0       : r_left;
        c_last  = i_cls.new_body ? 1'b0     : r_last;
        c_err   = i_cls.new_body ? ERR_NONE : r_err;

        n_phase = c_phase;
        n_acc   = c_acc;
        n_cnt   = c_cnt;
        n_left  = c_left;
        n_last  = c_last;
        n_err   = c_err;
        dvalid  = 1'b0;

        if (c_err == ERR_NONE) begin
            case (c_phase)
                PH_SIZE: begin
                    if (i_cls.is_hex) begin
                        // shifting in one more nibble overflows when the top nibble is set
                        if (c_cnt >= lim || c_acc[SIZE_W-1 -: 4] != 4'd0) begin
                            n_err = ERR_SIZE;
                        end else begin
                            n_acc = {c_acc[SIZE_W-5:0], i_cls.hex_val};
                            n_cnt = c_cnt + CNT_W'(1);
                        end
                    end else if (i_cls.is_cr && c_cnt != '0) begin
                        n_phase = PH_SIZE_LF;
                    end else begin
                        n_err = ERR_SIZE;
                    end
                end
                PH_SIZE_LF: begin
                    if (!i_cls.is_lf) begin
                        n_err = ERR_SIZE;
                    end else if (c_acc == '0) begin
                        n_last  = 1'b1;
                        n_phase = PH_TERM_CR;
                    end else begin
                        n_left  = c_acc;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    dvalid = 1'b1;
                    n_left = c_left - SIZE_W'(1);
                    if (c_left == SIZE_W'(1)) n_phase = PH_TERM_CR;
                end
                PH_TERM_CR: begin
                    if (i_cls.is_cr) n_phase = PH_TERM_LF;
                    else n_err = ERR_TERM;
                end
                PH_TERM_LF: begin
                    if (!i_cls.is_lf) begin
                        n_err = ERR_TERM;
                    end else if (c_last) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_phase = PH_SIZE;
                    end
                end
                default: begin
                end
            endcase
        end

        n_out_item.data_byte  = dvalid ? i_cls.raw : 8'h00;
        n_out_item.data_valid = dvalid;
        n_out_item.done_res   = (n_phase == PH_DONE);
        n_out_item.error_code = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIZE;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_last      <= 1'b0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_left  <= n_left;
                r_last  <= n_last;
                r_err   <= n_err;
            end
            // hold the result until its transfer completes
            if (o_pop) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hdl/chunked_body_decoder.sv
// Top level of the chunked body decoder: front, queue, back and config register.
// Decodes an HTTP chunked body one byte per transfer and returns one result per
// byte, in order. One byte is taken every clock while the output side keeps up:
// the back end's framing state machine updates once per cycle whenever it pops a
// queued byte, and a byte passes through the queue and then the output register
// on its way to its result. The queue holds QUEUE_DEPTH classified bytes; with
// bytes flowing one per clock, the input takes QUEUE_DEPTH - 1 more bytes after
// the output stalls before it stalls too.
// Write max_size_digits only while the decoder is idle; it resets to 8.
module chunked_body_decoder #(
    parameter int QUEUE_DEPTH = cbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cbd_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  cbd_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output cbd_pkg::t_out_item        o_out_item
);
    import cbd_pkg::*;

    logic [CNT_W-1:0] r_max_digits;
    logic             push, pop, q_full, q_empty;
    t_cls             front_cls, q_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_digits <= MAX_DIGITS_RST;
        end else if (i_cfg_we) begin
            r_max_digits <= i_cfg_data;
        end
    end

    cbd_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cls      (front_cls)
    );

    cbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .i_pop   (pop),
        .o_data  (q_cls),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_digits (r_max_digits),
        .i_cls        (q_cls),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

    // Payload is only ever passed out while the body is neither failed nor finished
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.data_valid) |->
            (o_out_item.error_code == ERR_NONE && !o_out_item.done_res))
        else $error("data byte passed out with error or done set");

    // A finished body never reports an error
    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.done_res) |-> (o_out_item.error_code == ERR_NONE))
        else $error("done and error reported together");

    // No result appears in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // Popping needs a queued byte
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

>>> dv/tb_chunked_body_decoder.sv
// Self-checking testbench for the chunked body decoder: framed bodies, noise and config sweeps.
module tb_chunked_body_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import cbd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_BYTES = 120;

    // Tracks the framing state in step with the block and holds the expected decoded bytes
    class decoded_byte_board;
        t_phase             phase;
        logic [SIZE_W-1:0]  size_acc;
        logic [CNT_W-1:0]   digits;
        logic [SIZE_W-1:0]  left;
        logic               last_seen;
        t_err               err;
        logic [CNT_W-1:0]   digit_cap;
        t_out_item          decoded_q[$];
        int                 fails;
        int                 noted_bytes;

        function new();
            digit_cap   = MAX_DIGITS_RST;
            fails       = 0;
            noted_bytes = 0;
            restart();
        endfunction

        function void restart();
            phase     = PH_SIZE;
            size_acc  = '0;
            digits    = '0;
            left      = '0;
            last_seen = 1'b0;
            err       = ERR_NONE;
        endfunction

        function void set_digit_cap(logic [CNT_W-1:0] v);
            digit_cap = v;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void note_byte(t_in_item it);
            t_out_item        res;
            logic [7:0]       c;
            logic             is_hex;
            logic [3:0]       nib;
            logic [35:0]      grown;
            logic [CNT_W-1:0] cap;
            c   = it.body_byte;
            res = '0;
            cap = digit_cap;
            if (digit_cap < 4'd1) cap = 4'd1;
            if (digit_cap > 4'd8) cap = 4'd8;
            is_hex = 1'b1;
            nib    = '0;
            if (c >= "0" && c <= "9")      nib = 4'(c - "0");
            else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
            else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
            else                           is_hex = 1'b0;

            if (it.new_body) restart();
            noted_bytes++;

            if (err == ERR_NONE) begin
                case (phase)
                    PH_SIZE: begin
                        grown = ({5'b0, size_acc} << 4) + 36'(nib);
                        if (is_hex) begin
                            if (digits >= cap || grown > 36'h07FFFFFFF) begin
                                err = ERR_SIZE;
                            end else begin
                                size_acc = grown[SIZE_W-1:0];
                                digits   = digits + CNT_W'(1);
                            end
                        end else if (c == CHR_CR && digits != 0) begin
                            phase = PH_SIZE_LF;
                        end else begin
                            err = ERR_SIZE;
                        end
                    end
                    PH_SIZE_LF: begin
                        if (c != CHR_LF) begin
                            err = ERR_SIZE;
                        end else if (size_acc == 0) begin
                            last_seen = 1'b1;
                            phase     = PH_TERM_CR;
                        end else begin
                            left  = size_acc;
                            phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        res.data_valid = 1'b1;
                        res.data_byte  = c;
                        left = left - SIZE_W'(1);
                        if (left == 0) phase = PH_TERM_CR;
                    end
                    PH_TERM_CR: begin
                        if (c == CHR_CR) phase = PH_TERM_LF;
                        else err = ERR_TERM;
                    end
                    PH_TERM_LF: begin
                        if (c != CHR_LF) begin
                            err = ERR_TERM;
                        end else if (last_seen) begin
                            phase = PH_DONE;
                        end else begin
                            size_acc = '0;
                            digits   = '0;
                            phase    = PH_SIZE;
                        end
                    end
                    default: ;
                endcase
            end
            res.done_res   = (phase == PH_DONE);
            res.error_code = err;
            decoded_q.push_back(res);
        endfunction

        function void check_decoded(t_out_item got);
            t_out_item want;
            if (decoded_q.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, actual %h",
                         $time, got);
                fails++;
                return;
            end
            want = decoded_q.pop_front();
            if (got.data_byte !== want.data_byte) begin
                $display("%0t: data_byte mismatch: expected %h, actual %h",
                         $time, want.data_byte, got.data_byte);
                fails++;
            end
            if (got.data_valid !== want.data_valid) begin
                $display("%0t: data_valid mismatch: expected %b, actual %b",
                         $time, want.data_valid, got.data_valid);
                fails++;
            end
            if (got.done_res !== want.done_res) begin
                $display("%0t: done_res mismatch: expected %b, actual %b",
                         $time, want.done_res, got.done_res);
                fails++;
            end
            if (got.error_code !== want.error_code) begin
                $display("%0t: error_code mismatch: expected %0d, actual %0d",
                         $time, want.error_code, got.error_code);
                fails++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_item;

    decoded_byte_board board;
    logic [7:0]        frame_q[$];
    logic              idle_in;
    logic              idle_out;
    int                hold_left;
    int                cycles;

    chunked_body_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Note accepted transfers on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.note_byte(i_in_item);
            if (o_out_valid && !i_out_stall) begin
                board.check_decoded(o_out_item);
                hold_left = idle_out ? $urandom_range(0, 10) : 0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fresh);
        int gap;
        gap = idle_in ? $urandom_range(0, 10) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid          <= 1'b1;
        i_in_item.body_byte <= b;
        i_in_item.new_body  <= fresh;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i], i == 0);
        frame_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
    endtask

    task automatic push_crlf();
        frame_q.push_back(CHR_CR);
        frame_q.push_back(CHR_LF);
    endtask

    // Size line with leading zeros out to nd digits, each hex letter in a random case
    task automatic push_size(input logic [31:0] value, input int nd);
        logic [3:0] nib;
        logic [7:0] ch;
        for (int i = nd - 1; i >= 0; i--) begin
            nib = (i < 8) ? value[i*4 +: 4] : 4'h0;
            if (nib < 10)          ch = 8'h30 + 8'(nib);
            else if ($urandom % 2) ch = "A" + 8'(nib - 10);
            else                   ch = "a" + 8'(nib - 10);
            frame_q.push_back(ch);
        end
        push_crlf();
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom % 6)
            0:       return CHR_CR;
            1:       return CHR_LF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic build_body(input int cap);
        int nd;
        int sz;
        int at;
        frame_q.delete();
        repeat ($urandom_range(0, 3)) begin
            nd = $urandom_range(1, cap);
            if ($urandom % 16 == 0) nd = cap + 1;
            if (nd >= 2 && $urandom % 8 == 0) sz = $urandom_range(25, 200);
            else sz = $urandom_range(1, nd >= 2 ? 24 : 15);
            push_size(sz, nd);
            repeat (sz) frame_q.push_back(payload_byte());
            push_crlf();
        end
        push_size(0, $urandom_range(1, cap));
        push_crlf();
        if ($urandom % 4 == 0) repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
        // Damage a quarter of the bodies
        if ($urandom % 4 == 0) begin
            at = $urandom_range(0, frame_q.size() - 1);
            case ($urandom % 4)
                0: frame_q[at] = 8'($urandom);
                1: frame_q.insert(at, 8'($urandom));
                2: begin
                    frame_q.delete();
                    push_size($urandom | 32'h8000_0000, 8);
                    repeat ($urandom_range(0, 4)) frame_q.push_back(payload_byte());
                end
                default: if (frame_q.size() > 1) frame_q.delete(at);
            endcase
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_digit_cap(input logic [CNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_digit_cap(v);
    endtask

    initial begin
        logic [CNT_W-1:0] caps[10];
        int               cap;
        int               goal;
        caps = '{4'd8, 4'd0, 4'd1, 4'd2, 4'd3, 4'd15, 4'd5, 4'd9, 4'd4, 4'd8};
        board      = new();
        cycles     = 0;
        hold_left  = 0;
        idle_in    = 1'b1;
        idle_out   = 1'b1;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        i_out_stall = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Data holding CR and the byte extremes, done, then a byte after done
        push_text("3"); push_crlf();
        frame_q.push_back(CHR_CR); frame_q.push_back(8'h00); frame_q.push_back(8'hFF);
        push_crlf(); push_text("0"); push_crlf(); push_crlf(); push_text("x");
        send_frame();
        // Empty size line, then a digit that must be ignored
        frame_q.push_back(CHR_CR); push_text("1"); send_frame();
        push_text("g"); send_frame();
        push_text("F"); frame_q.push_back(CHR_CR); push_text("x"); send_frame();
        // Bad terminator after data and after the zero chunk
        push_text("2"); push_crlf(); push_text("abxy"); send_frame();
        push_text("0"); push_crlf(); push_text("Z"); send_frame();
        // Size above the limit, the largest size, and one digit too many
        push_text("80000000"); send_frame();
        push_text("7fffffff"); push_crlf(); frame_q.push_back(8'h00); send_frame();
        push_text("000000001"); send_frame();
        drain();

        for (int p = 0; p < 10; p++) begin
            if (p > 0) write_digit_cap(caps[p]);
            cap = (caps[p] < 1) ? 1 : (caps[p] > 8) ? 8 : caps[p];
            idle_in  = (p % 4 == 0) || (p % 4 == 1);
            idle_out = (p % 4 == 0) || (p % 4 == 2);
            goal = board.noted_bytes + PHASE_BYTES;
            while (board.noted_bytes < goal) begin
                if ($urandom % 10 == 0) begin
                    repeat ($urandom_range(1, 8))
                        send_byte(8'($urandom), $urandom % 8 == 0);
                end else begin
                    build_body(cap);
                    send_frame();
                end
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (board.fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
